[sv/aca_pkg.sv]
// ----------------------------------------------------------------------------
// aca_pkg: shared types and constants for the affinity core allocator
// Item structs, result codes and the controller/datapath command interface.
// ----------------------------------------------------------------------------
package aca_pkg;

  // parameter defaults
  localparam int unsigned MAX_CORES_DEF     = 64;
  localparam int unsigned THREAD_SLOTS_DEF  = 16;
  localparam int unsigned PENDING_DEPTH_DEF = 8;

  // fixed field widths
  localparam int unsigned MaskW = 64;
  localparam int unsigned CoreW = 6;
  localparam int unsigned TidW  = 4;
  localparam int unsigned CntW  = 7;
  localparam int unsigned CodeW = 3;

  // result codes
  localparam logic [CodeW-1:0] EV_GRANTED      = 3'd0;
  localparam logic [CodeW-1:0] EV_BLOCKED      = 3'd1;
  localparam logic [CodeW-1:0] EV_PEND_GRANTED = 3'd2;
  localparam logic [CodeW-1:0] EV_RELEASED     = 3'd3;
  localparam logic [CodeW-1:0] EV_REFUSED      = 3'd4;

  // actions
  localparam logic ACT_RESERVE = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  typedef struct packed {
    logic             action;
    logic [TidW-1:0]  thread_id;
    logic [CntW-1:0]  cores_count;
    logic [MaskW-1:0] affinity_mask;
  } aca_in_t;

  typedef struct packed {
    logic [CodeW-1:0] event_code;
    logic [TidW-1:0]  target_thread;
    logic [MaskW-1:0] granted_mask;
    logic [MaskW-1:0] free_mask;
    logic             last_result;
  } aca_out_t;

  // controller to datapath
  typedef struct packed {
    logic latch;        // capture input item
    logic load_item;    // start grant scan from the input item
    logic load_pend;    // start grant scan from pending entry p
    logic scan;         // one scan step
    logic end_reserve;  // resolve a reserve request
    logic end_retry;    // resolve a pending retry, advance p
    logic pop_rd;       // read top of the thread's core stack
    logic pop_wr;       // free the popped core
    logic rel_done;     // stage release result, open retry pass
    logic close_retry;  // commit compacted pending count
    logic flush;        // move staged result out as the last one
  } aca_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_release;
    logic scan_done;
    logic can_stage;
    logic out_free;
    logic pop_more;
    logic retry_more;
    logic stg_valid;
  } aca_sts_t;

endpackage

[sv/aca_ctrl.sv]
// ----------------------------------------------------------------------------
// aca_ctrl: allocator sequencer
// Steps each request through scan, release pops, pending retries and flush.
// ----------------------------------------------------------------------------
module aca_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  aca_pkg::aca_sts_t sts_i,
  output aca_pkg::aca_cmd_t cmd_o
);
  import aca_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_DISPATCH = 8'b0000_0010,
    ST_SCAN     = 8'b0000_0100,
    ST_GEND     = 8'b0000_1000,
    ST_POP      = 8'b0001_0000,
    ST_POPWR    = 8'b0010_0000,
    ST_RETRY    = 8'b0100_0000,
    ST_FLUSH    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (sts_i.is_release) begin
          state_d = ST_POP;
        end else begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = ST_GEND;
        end else begin
          cmd_o.scan = 1'b1;
        end
      end
      ST_GEND: begin
        if (sts_i.can_stage) begin
          if (sts_i.is_release) begin
            cmd_o.end_retry = 1'b1;
            state_d         = ST_RETRY;
          end else begin
            cmd_o.end_reserve = 1'b1;
            state_d           = ST_FLUSH;
          end
        end
      end
      ST_POP: begin
        if (sts_i.pop_more) begin
          cmd_o.pop_rd = 1'b1;
          state_d      = ST_POPWR;
        end else if (sts_i.can_stage) begin
          cmd_o.rel_done = 1'b1;
          state_d        = ST_RETRY;
        end
      end
      ST_POPWR: begin
        cmd_o.pop_wr = 1'b1;
        state_d      = ST_POP;
      end
      ST_RETRY: begin
        if (sts_i.retry_more) begin
          cmd_o.load_pend = 1'b1;
          state_d         = ST_SCAN;
        end else begin
          cmd_o.close_retry = 1'b1;
          state_d           = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (sts_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[sv/aca_dp.sv]
// ----------------------------------------------------------------------------
// aca_dp: allocator datapath
// Free map, per-thread core stacks, pending queue, bit scanner, result stage.
// ----------------------------------------------------------------------------
module aca_dp #(
  parameter int unsigned MAX_CORES     = aca_pkg::MAX_CORES_DEF,
  parameter int unsigned THREAD_SLOTS  = aca_pkg::THREAD_SLOTS_DEF,
  parameter int unsigned PENDING_DEPTH = aca_pkg::PENDING_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [aca_pkg::CntW-1:0]   cfg_data_i,
  input  aca_pkg::aca_in_t           in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output aca_pkg::aca_out_t          out_item_o,
  input  aca_pkg::aca_cmd_t          cmd_i,
  output aca_pkg::aca_sts_t          sts_o
);
  import aca_pkg::*;

  localparam int unsigned TIdxW    = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
  localparam int unsigned OrdDepth = THREAD_SLOTS * MAX_CORES;
  localparam int unsigned OrdAW    = (OrdDepth > 1) ? $clog2(OrdDepth) : 1;
  localparam int unsigned PdW      = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int unsigned PcW      = $clog2(PENDING_DEPTH + 1);
  localparam int unsigned ThrCmpW  = 9;
  localparam int unsigned PosW     = CntW + 1;

  // configuration
  logic [CntW-1:0]  cores_in_use_q;
  logic [CntW-1:0]  n_eff;
  logic [MaskW-1:0] present;

  // request and scan context
  aca_in_t          item_q;
  logic [TidW-1:0]  ctx_thr_q;
  logic [CntW-1:0]  ctx_need_q;
  logic [MaskW-1:0] ctx_mask_q;
  logic [MaskW-1:0] scan_vec_q;
  logic [CoreW-1:0] scan_idx_q;
  logic [CntW-1:0]  found_q;
  logic [MaskW-1:0] pick_q;
  logic [CntW-1:0]  rel_n_q;

  // allocation state
  logic [MaskW-1:0] free_q;
  logic [CntW-1:0]  tcount_q [THREAD_SLOTS];
  logic [CoreW-1:0] ord_mem [OrdDepth];
  logic [CoreW-1:0] ord_rdata_q;

  // pending queue
  logic [TidW-1:0]  pend_thr_q  [PENDING_DEPTH];
  logic [CntW-1:0]  pend_cnt_q  [PENDING_DEPTH];
  logic [MaskW-1:0] pend_mask_q [PENDING_DEPTH];
  logic [PcW-1:0]   pcount_q;
  logic [PcW-1:0]   p_q;
  logic [PcW-1:0]   w_q;

  // result stage and output register
  aca_out_t         stg_q;
  logic             stg_v_q;
  aca_out_t         out_q;
  logic             out_v_q;

  logic [TIdxW-1:0] tidx;
  logic             thr_ok;
  logic [CntW-1:0]  cur_cnt;
  logic [PosW-1:0]  pos;
  logic [OrdAW-1:0] ord_base;
  logic [OrdAW-1:0] ord_waddr;
  logic [OrdAW-1:0] ord_raddr;
  logic             ord_we;
  logic             scan_done;
  logic             grant_ok;
  logic             room;
  logic             out_free;
  logic             stage_en;
  aca_out_t         stage_item;
  aca_out_t         flush_item;
  logic             out_load;
  logic             enq;

  // present core mask
  always_comb begin
    n_eff   = (cores_in_use_q > CntW'(MAX_CORES)) ? CntW'(MAX_CORES) : cores_in_use_q;
    present = (n_eff >= CntW'(MaskW)) ? '1 : ((MaskW'(1) << n_eff) - MaskW'(1));
  end

  // thread and stack addressing
  assign tidx      = TIdxW'(ctx_thr_q);
  assign thr_ok    = ThrCmpW'(ctx_thr_q) < ThrCmpW'(THREAD_SLOTS);
  assign cur_cnt   = tcount_q[tidx];
  assign pos       = PosW'(cur_cnt) + PosW'(found_q);
  assign ord_base  = OrdAW'(tidx) * OrdAW'(MAX_CORES);
  assign ord_waddr = ord_base + OrdAW'(pos);
  assign ord_raddr = ord_base + OrdAW'(cur_cnt - CntW'(1));

  // scan status
  assign scan_done = !thr_ok || (found_q == ctx_need_q) || (scan_vec_q == '0);
  assign grant_ok  = thr_ok && (found_q == ctx_need_q);
  assign ord_we    = cmd_i.scan && !scan_done && scan_vec_q[0] && (pos < PosW'(MAX_CORES));
  assign room      = pcount_q < PcW'(PENDING_DEPTH);
  assign out_free  = !out_v_q || out_ready_i;
  assign enq       = cmd_i.end_reserve && !grant_ok && thr_ok && room;

  // result to stage
  always_comb begin
    stage_en   = 1'b0;
    stage_item = '0;
    stage_item.target_thread = ctx_thr_q;
    stage_item.free_mask     = free_q;
    if (cmd_i.end_reserve) begin
      stage_en = 1'b1;
      if (grant_ok) begin
        stage_item.event_code   = EV_GRANTED;
        stage_item.granted_mask = pick_q;
        stage_item.free_mask    = free_q & ~pick_q;
      end else if (thr_ok && room) begin
        stage_item.event_code = EV_BLOCKED;
      end else begin
        stage_item.event_code = EV_REFUSED;
      end
    end else if (cmd_i.end_retry && grant_ok) begin
      stage_en                = 1'b1;
      stage_item.event_code   = EV_PEND_GRANTED;
      stage_item.granted_mask = pick_q;
      stage_item.free_mask    = free_q & ~pick_q;
    end else if (cmd_i.rel_done) begin
      stage_en                 = 1'b1;
      stage_item.event_code    = EV_RELEASED;
      stage_item.target_thread = item_q.thread_id;
    end
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cores_in_use_q <= CntW'(MaskW);
    end else if (cfg_we_i) begin
      cores_in_use_q <= cfg_data_i;
    end
  end

  // request capture and bit scanner
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q    <= in_item_i;
      ctx_thr_q <= in_item_i.thread_id;
      rel_n_q   <= '0;
    end
    if (cmd_i.load_item) begin
      ctx_need_q <= item_q.cores_count;
      ctx_mask_q <= item_q.affinity_mask;
      scan_vec_q <= item_q.affinity_mask & free_q & present;
      scan_idx_q <= '0;
      found_q    <= '0;
      pick_q     <= '0;
    end
    if (cmd_i.load_pend) begin
      ctx_thr_q  <= pend_thr_q[PdW'(p_q)];
      ctx_need_q <= pend_cnt_q[PdW'(p_q)];
      ctx_mask_q <= pend_mask_q[PdW'(p_q)];
      scan_vec_q <= pend_mask_q[PdW'(p_q)] & free_q & present;
      scan_idx_q <= '0;
      found_q    <= '0;
      pick_q     <= '0;
    end
    if (cmd_i.scan && !scan_done) begin
      if (scan_vec_q[0]) begin
        found_q <= found_q + CntW'(1);
        pick_q  <= pick_q | (MaskW'(1) << scan_idx_q);
      end
      scan_vec_q <= scan_vec_q >> 1;
      scan_idx_q <= scan_idx_q + CoreW'(1);
    end
    if (cmd_i.pop_rd) begin
      rel_n_q <= rel_n_q + CntW'(1);
    end
  end

  // free map and per-thread stack depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= '1;
      for (int i = 0; i < int'(THREAD_SLOTS); i++) begin
        tcount_q[i] <= '0;
      end
    end else begin
      if ((cmd_i.end_reserve || cmd_i.end_retry) && grant_ok) begin
        free_q         <= free_q & ~pick_q;
        tcount_q[tidx] <= cur_cnt + found_q;
      end
      if (cmd_i.pop_rd) begin
        tcount_q[tidx] <= cur_cnt - CntW'(1);
      end
      if (cmd_i.pop_wr) begin
        free_q <= free_q | (MaskW'(1) << ord_rdata_q);
      end
    end
  end

  // core order stacks
  always_ff @(posedge clk_i) begin
    if (ord_we) begin
      ord_mem[ord_waddr] <= scan_idx_q;
    end
    if (cmd_i.pop_rd) begin
      ord_rdata_q <= ord_mem[ord_raddr];
    end
  end

  // pending queue entries
  always_ff @(posedge clk_i) begin
    if (enq) begin
      pend_thr_q[PdW'(pcount_q)]  <= ctx_thr_q;
      pend_cnt_q[PdW'(pcount_q)]  <= ctx_need_q;
      pend_mask_q[PdW'(pcount_q)] <= ctx_mask_q;
    end
    if (cmd_i.end_retry && !grant_ok) begin
      pend_thr_q[PdW'(w_q)]  <= ctx_thr_q;
      pend_cnt_q[PdW'(w_q)]  <= ctx_need_q;
      pend_mask_q[PdW'(w_q)] <= ctx_mask_q;
    end
  end

  // pending queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcount_q <= '0;
      p_q      <= '0;
      w_q      <= '0;
    end else begin
      if (enq) begin
        pcount_q <= pcount_q + PcW'(1);
      end
      if (cmd_i.rel_done) begin
        p_q <= '0;
        w_q <= '0;
      end
      if (cmd_i.end_retry) begin
        p_q <= p_q + PcW'(1);
        if (!grant_ok) begin
          w_q <= w_q + PcW'(1);
        end
      end
      if (cmd_i.close_retry) begin
        pcount_q <= w_q;
      end
    end
  end

  // final result of a request carries the last marker
  always_comb begin
    flush_item             = stg_q;
    flush_item.last_result = 1'b1;
  end

  // output register loads on a flush or when a staged result is pushed out
  assign out_load = cmd_i.flush || (stage_en && stg_v_q);

  // stage and output valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (cmd_i.flush) begin
        stg_v_q <= 1'b0;
      end else if (stage_en) begin
        stg_v_q <= 1'b1;
      end
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // stage and output payload
  always_ff @(posedge clk_i) begin
    if (stage_en) begin
      stg_q <= stage_item;
    end
    if (cmd_i.flush) begin
      out_q <= flush_item;
    end else if (stage_en && stg_v_q) begin
      out_q <= stg_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

  // status to the controller
  always_comb begin
    sts_o            = '0;
    sts_o.is_release = (item_q.action == ACT_RELEASE);
    sts_o.scan_done  = scan_done;
    sts_o.can_stage  = !stg_v_q || out_free;
    sts_o.out_free   = out_free;
    sts_o.pop_more   = thr_ok && (rel_n_q < item_q.cores_count) && (cur_cnt != '0);
    sts_o.retry_more = p_q < pcount_q;
    sts_o.stg_valid  = stg_v_q;
  end

endmodule

[sv/affinity_core_allocator.sv]
// Reserve steps through dispatch, a bit scan up to the last core picked, grant
// resolve and flush; release pops and frees each core, then retries every
// queued request with its own scan. One request is in work at a time; the
// bit scanner, the stack memory port and result-side stalls set how long it takes.
// Reset: all cores free, no cores held, pending queue empty, core count 64 (capped at MAX_CORES).
// ----------------------------------------------------------------------------
// affinity_core_allocator: core allocator under per-thread affinity masks
// Grants lowest free allowed cores all or none, queues misses while room, retries on release.
// ----------------------------------------------------------------------------
module affinity_core_allocator #(
  parameter int unsigned MAX_CORES     = aca_pkg::MAX_CORES_DEF,
  parameter int unsigned THREAD_SLOTS  = aca_pkg::THREAD_SLOTS_DEF,
  parameter int unsigned PENDING_DEPTH = aca_pkg::PENDING_DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [aca_pkg::CntW-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  aca_pkg::aca_in_t         in_item_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output aca_pkg::aca_out_t        out_item_o
);
  import aca_pkg::*;

  aca_cmd_t cmd;
  aca_sts_t sts;

  // sequencer
  aca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  aca_dp #(
    .MAX_CORES     (MAX_CORES),
    .THREAD_SLOTS  (THREAD_SLOTS),
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

`ifndef NO_ASSERTIONS
  // no staged result may be left behind when a new transfer can be taken
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !sts.stg_valid)
    else $error("staged result left while idle");

  // an accepted request keeps the block busy the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready right after accept");

  // a flush always presents the final result of the request
  a_flush_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.flush |=> (out_valid_o && out_item_o.last_result))
    else $error("flush without last result");
`endif

endmodule
